/* hdl/dda_pkg.sv */
package dda_pkg;

	// Coordinate and fixed-point formats
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int ACC_W      = COORD_BITS + FRAC_BITS;
	localparam int INC_W      = FRAC_BITS + 2;
	localparam int QUO_W      = FRAC_BITS + 1;
	localparam int CNT_W      = $clog2(FRAC_BITS + 1);

	// Input action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic start;     // start item transferred
		logic step;      // step item transferred
		logic div_step;  // run one quotient bit
		logic div_first; // first quotient bit, no remainder shift
		logic finish;    // sign the quotients, emit the first pixel
		logic emit;      // load the output register
	} dp_cmd_t;

endpackage

/* hdl/dda_ctrl.sv */
module dda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              steps_zero,
	output dda_pkg::dp_cmd_t  cmd
);
	import dda_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             xfer;
	logic             start_xfer;
	logic             step_xfer;

	// Take an item only in idle with the output slot free or draining
	assign in_ready   = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign xfer       = in_valid && in_ready;
	assign start_xfer = xfer && (action == ACT_START);
	assign step_xfer  = xfer && (action == ACT_STEP);
	assign out_valid  = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.start     = start_xfer;
		cmd.step      = step_xfer;
		cmd.div_step  = (state_q == ST_DIV);
		cmd.div_first = (state_q == ST_DIV) && (cnt_q == '0);
		cmd.finish    = (state_q == ST_FIN);
		cmd.emit      = (start_xfer && steps_zero) || step_xfer || (state_q == ST_FIN);
	end

	// Sequence: idle, one quotient bit per cycle, then finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start_xfer && !steps_zero) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(FRAC_BITS)) begin
						state_q <= ST_FIN;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* hdl/dda_dp.sv */
module dda_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dda_pkg::dp_cmd_t                    cmd,
	input  logic [dda_pkg::COORD_BITS-1:0]      x_start,
	input  logic [dda_pkg::COORD_BITS-1:0]      y_start,
	input  logic [dda_pkg::COORD_BITS-1:0]      x_end,
	input  logic [dda_pkg::COORD_BITS-1:0]      y_end,
	output logic                                steps_zero,
	output logic [dda_pkg::COORD_BITS-1:0]      pixel_x,
	output logic [dda_pkg::COORD_BITS-1:0]      pixel_y,
	output logic                                active,
	output logic                                last
);
	import dda_pkg::*;

	localparam logic [ACC_W:0] RND_HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

	logic [COORD_BITS:0]   dx, dy;
	logic [COORD_BITS-1:0] ax, ay, steps;

	logic [COORD_BITS-1:0] steps_q;
	logic [COORD_BITS-1:0] rem_x_q, rem_y_q;
	logic [QUO_W-1:0]      quo_x_q, quo_y_q;
	logic                  neg_x_q, neg_y_q;
	logic [ACC_W-1:0]      acc_x_q, acc_y_q;
	logic [INC_W-1:0]      inc_x_q, inc_y_q;
	logic [COORD_BITS-1:0] left_q;
	logic                  busy_q;

	logic [COORD_BITS:0]   tx, ty, nrx, nry;
	logic                  bx, by;
	logic [INC_W-1:0]      inc_x_new, inc_y_new;
	logic [ACC_W-1:0]      add_x, add_y, acc_x_nx, acc_y_nx;
	logic [ACC_W:0]        rnd_x, rnd_y;
	logic                  is_last;

	// Deltas, magnitudes and step count straight from the start item
	assign dx    = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
	assign dy    = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
	assign ax    = dx[COORD_BITS] ? COORD_BITS'(~dx + 1'b1) : dx[COORD_BITS-1:0];
	assign ay    = dy[COORD_BITS] ? COORD_BITS'(~dy + 1'b1) : dy[COORD_BITS-1:0];
	assign steps = (ax >= ay) ? ax : ay;
	assign steps_zero = (steps == '0);

	// Restoring divide, one quotient bit per cycle for both axes
	assign tx  = cmd.div_first ? {1'b0, rem_x_q} : {rem_x_q, 1'b0};
	assign ty  = cmd.div_first ? {1'b0, rem_y_q} : {rem_y_q, 1'b0};
	assign bx  = (tx >= {1'b0, steps_q});
	assign by  = (ty >= {1'b0, steps_q});
	assign nrx = bx ? tx - {1'b0, steps_q} : tx;
	assign nry = by ? ty - {1'b0, steps_q} : ty;

	// Apply the sign to the truncated quotient magnitude
	assign inc_x_new = neg_x_q ? INC_W'(~{1'b0, quo_x_q} + 1'b1) : {1'b0, quo_x_q};
	assign inc_y_new = neg_y_q ? INC_W'(~{1'b0, quo_y_q} + 1'b1) : {1'b0, quo_y_q};

	// Advance the accumulators on a step, hold them otherwise
	assign add_x    = cmd.step ? {{(ACC_W-INC_W){inc_x_q[INC_W-1]}}, inc_x_q} : '0;
	assign add_y    = cmd.step ? {{(ACC_W-INC_W){inc_y_q[INC_W-1]}}, inc_y_q} : '0;
	assign acc_x_nx = acc_x_q + add_x;
	assign acc_y_nx = acc_y_q + add_y;

	// Round half away from zero: add a half, less one when negative, then floor
	assign rnd_x = {acc_x_nx[ACC_W-1], acc_x_nx} + RND_HALF
		- {{ACC_W{1'b0}}, acc_x_nx[ACC_W-1]};
	assign rnd_y = {acc_y_nx[ACC_W-1], acc_y_nx} + RND_HALF
		- {{ACC_W{1'b0}}, acc_y_nx[ACC_W-1]};

	assign is_last = (left_q == COORD_BITS'(1));

	// Line state: load on start, divide, then advance per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			rem_x_q <= '0;
			rem_y_q <= '0;
			quo_x_q <= '0;
			quo_y_q <= '0;
			neg_x_q <= 1'b0;
			neg_y_q <= 1'b0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			inc_x_q <= '0;
			inc_y_q <= '0;
			left_q  <= '0;
			busy_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				steps_q <= steps;
				rem_x_q <= ax;
				rem_y_q <= ay;
				quo_x_q <= '0;
				quo_y_q <= '0;
				neg_x_q <= dx[COORD_BITS];
				neg_y_q <= dy[COORD_BITS];
				acc_x_q <= {x_start, {FRAC_BITS{1'b0}}};
				acc_y_q <= {y_start, {FRAC_BITS{1'b0}}};
				inc_x_q <= '0;
				inc_y_q <= '0;
				left_q  <= steps;
				busy_q  <= !steps_zero;
			end
			if (cmd.div_step) begin
				rem_x_q <= nrx[COORD_BITS-1:0];
				rem_y_q <= nry[COORD_BITS-1:0];
				quo_x_q <= {quo_x_q[QUO_W-2:0], bx};
				quo_y_q <= {quo_y_q[QUO_W-2:0], by};
			end
			if (cmd.finish) begin
				inc_x_q <= inc_x_new;
				inc_y_q <= inc_y_new;
			end
			if (cmd.step && busy_q) begin
				acc_x_q <= acc_x_nx;
				acc_y_q <= acc_y_nx;
				left_q  <= left_q - 1'b1;
				busy_q  <= !is_last;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_x <= '0;
			pixel_y <= '0;
			active  <= 1'b0;
			last    <= 1'b0;
		end else if (cmd.emit) begin
			if (cmd.start) begin
				pixel_x <= x_start;
				pixel_y <= y_start;
				active  <= 1'b1;
				last    <= 1'b1;
			end else if (cmd.step && !busy_q) begin
				pixel_x <= '0;
				pixel_y <= '0;
				active  <= 1'b0;
				last    <= 1'b0;
			end else begin
				pixel_x <= rnd_x[FRAC_BITS +: COORD_BITS];
				pixel_y <= rnd_y[FRAC_BITS +: COORD_BITS];
				active  <= 1'b1;
				last    <= cmd.step && is_last;
			end
		end
	end

endmodule

/* hdl/dda_line_rasterizer.sv */
// Channel  | handshake               | payload
// ---------+-------------------------+-------------------------------------------
// in       | in_valid / in_ready     | action, x_start, y_start, x_end, y_end
// out      | out_valid / out_ready   | pixel_x, pixel_y, active, last
//
// Steps stream at one per cycle while the output is not stalled.
// A zero-length start needs no divide; any other start holds in_ready low after
// its transfer through the divide and finish states, while the restoring divider
// yields one increment bit per cycle for both axes at once.
// Results appear in the output register the cycle after the work ends.
// A stalled output holds; new items are taken once the output drains.
// Reset clears the line state; after it no line is active.
module dda_line_rasterizer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [dda_pkg::COORD_BITS-1:0] x_start,
	input  logic [dda_pkg::COORD_BITS-1:0] y_start,
	input  logic [dda_pkg::COORD_BITS-1:0] x_end,
	input  logic [dda_pkg::COORD_BITS-1:0] y_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [dda_pkg::COORD_BITS-1:0] pixel_x,
	output logic [dda_pkg::COORD_BITS-1:0] pixel_y,
	output logic                           active,
	output logic                           last
);
	import dda_pkg::*;

	dp_cmd_t cmd;
	logic    steps_zero;

	dda_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.steps_zero (steps_zero),
		.cmd        (cmd)
	);

	dda_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.steps_zero (steps_zero),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.active     (active),
		.last       (last)
	);

endmodule

/* hdl/dda_chk.sv */
module dda_chk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           action,
	input  logic [dda_pkg::COORD_BITS-1:0] x_start,
	input  logic [dda_pkg::COORD_BITS-1:0] y_start,
	input  logic [dda_pkg::COORD_BITS-1:0] x_end,
	input  logic [dda_pkg::COORD_BITS-1:0] y_end,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [dda_pkg::COORD_BITS-1:0] pixel_x,
	input  logic [dda_pkg::COORD_BITS-1:0] pixel_y,
	input  logic                           active,
	input  logic                           last
);
	import dda_pkg::*;

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(active) && $stable(last))
		else $error("result changed while stalled");

	// An inactive result carries no pixel and no end mark
	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> pixel_x == '0 && pixel_y == '0 && !last)
		else $error("inactive result not cleared");

	// A step transfer yields a result in the next cycle
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_STEP |=> out_valid)
		else $error("step gave no result");

	// Input is taken only when the output slot is free or draining
	a_ready_slot: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_ready)
		else $error("input taken over a stalled result");

endmodule

bind dda_line_rasterizer dda_chk u_chk (.*);
